[hw/rtl/tcpop_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpop_pkg
// Shared types and constants for the TCP option parser.
// ----------------------------------------------------------------------------
package tcpop_pkg;

	localparam int DEF_MAX_OPTION_BYTES = 40;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_DEFAULT_MSS    = 2'd0,
		REG_DEFAULT_WSCALE = 2'd1,
		REG_TS_ENABLED     = 2'd2
	} reg_idx_t;

	localparam logic [15:0] RST_DEFAULT_MSS    = 16'd1460;
	localparam logic [3:0]  RST_DEFAULT_WSCALE = 4'd0;
	localparam logic        RST_TS_ENABLED     = 1'b1;

	localparam logic [7:0] KIND_EOL       = 8'd0;
	localparam logic [7:0] KIND_NOP       = 8'd1;
	localparam logic [7:0] KIND_MSS       = 8'd2;
	localparam logic [7:0] KIND_WSCALE    = 8'd3;
	localparam logic [7:0] KIND_SACK_PERM = 8'd4;
	localparam logic [7:0] KIND_TIMESTAMP = 8'd8;

	localparam logic [7:0] MIN_OPT_LEN       = 8'd2;
	localparam logic [7:0] MSS_BODY_BYTES    = 8'd2;
	localparam logic [7:0] WSCALE_BODY_BYTES = 8'd1;
	localparam logic [7:0] TS_BODY_BYTES     = 8'd8;
	localparam logic [7:0] TS_TSVAL_END      = 8'd4;
	localparam logic [15:0] TS_MSS_REDUCTION = 16'd12;
	localparam logic [5:0] POS_MAX           = 6'd63;

	typedef enum logic [2:0] {
		PH_KIND      = 3'd0,
		PH_LENGTH    = 3'd1,
		PH_DATA      = 3'd2,
		PH_SKIP      = 3'd3,
		PH_STOPPED   = 3'd4,
		PH_MALFORMED = 3'd5
	} phase_t;

	typedef struct packed {
		logic [15:0] default_mss;
		logic [3:0]  default_wscale;
		logic        timestamps_enabled;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  option_byte;
		logic [5:0]  area_length;
		logic        last_byte;
		logic [31:0] current_time;
	} byte_req_t;

	typedef struct packed {
		logic [15:0] mss_value;
		logic [15:0] effective_mss;
		logic        mss_seen;
		logic [7:0]  window_scale;
		logic        sack_permitted;
		logic        timestamp_seen;
		logic [31:0] recent_timestamp;
		logic [31:0] timestamp_update_time;
		logic        malformed;
	} summary_t;

endpackage

[hw/rtl/tcpop_byte_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpop_byte_if
// Option byte channel: one option area byte per request.
// ----------------------------------------------------------------------------
interface tcpop_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  option_byte;
	logic [5:0]  area_length;
	logic        last_byte;
	logic [31:0] current_time;

	modport source (
		output valid, option_byte, area_length, last_byte, current_time,
		input  ready
	);
	modport sink (
		input  valid, option_byte, area_length, last_byte, current_time,
		output ready
	);
endinterface

[hw/rtl/tcpop_summary_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpop_summary_if
// Summary channel: one parse summary per request.
// ----------------------------------------------------------------------------
interface tcpop_summary_if;
	logic        valid;
	logic        ready;
	logic [15:0] mss_value;
	logic [15:0] effective_mss;
	logic        mss_seen;
	logic [7:0]  window_scale;
	logic        sack_permitted;
	logic        timestamp_seen;
	logic [31:0] recent_timestamp;
	logic [31:0] timestamp_update_time;
	logic        malformed;

	modport source (
		output valid, mss_value, effective_mss, mss_seen, window_scale, sack_permitted,
		       timestamp_seen, recent_timestamp, timestamp_update_time, malformed,
		input  ready
	);
	modport sink (
		input  valid, mss_value, effective_mss, mss_seen, window_scale, sack_permitted,
		       timestamp_seen, recent_timestamp, timestamp_update_time, malformed,
		output ready
	);
endinterface

[hw/rtl/tcpop_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpop_cfg
// APB register file holding the parser defaults.
// ----------------------------------------------------------------------------
module tcpop_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tcpop_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [tcpop_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [tcpop_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready,
	output tcpop_pkg::cfg_t                     cfg
);

	tcpop_pkg::cfg_t cfg_q;
	logic [1:0]      idx;
	logic            wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_mss        <= tcpop_pkg::RST_DEFAULT_MSS;
			cfg_q.default_wscale     <= tcpop_pkg::RST_DEFAULT_WSCALE;
			cfg_q.timestamps_enabled <= tcpop_pkg::RST_TS_ENABLED;
		end else if (wr_en) begin
			unique case (idx)
				tcpop_pkg::REG_DEFAULT_MSS:    cfg_q.default_mss        <= pwdata[15:0];
				tcpop_pkg::REG_DEFAULT_WSCALE: cfg_q.default_wscale     <= pwdata[3:0];
				tcpop_pkg::REG_TS_ENABLED:     cfg_q.timestamps_enabled <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tcpop_pkg::REG_DEFAULT_MSS:    prdata = {16'd0, cfg_q.default_mss};
			tcpop_pkg::REG_DEFAULT_WSCALE: prdata = {28'd0, cfg_q.default_wscale};
			tcpop_pkg::REG_TS_ENABLED:     prdata = {31'd0, cfg_q.timestamps_enabled};
			default:                       prdata = '0;
		endcase
	end

endmodule

[hw/rtl/tcpop_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpop_core
// Input register, per-byte option parse and summary output register.
// ----------------------------------------------------------------------------
module tcpop_core #(
	parameter int MAX_OPTION_BYTES = tcpop_pkg::DEF_MAX_OPTION_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tcpop_pkg::cfg_t        cfg,
	tcpop_byte_if.sink             opt_bytes,
	tcpop_summary_if.source        summary
);

	localparam logic [5:0] MAX_AREA = 6'(MAX_OPTION_BYTES);

	// input stage
	logic                 valid_s1;
	tcpop_pkg::byte_req_t req_s1;
	logic                 advance;
	logic                 accept;

	// parse state
	tcpop_pkg::phase_t phase_q, phase_nxt;
	logic [5:0]  pos_q, pos_nxt;
	logic [7:0]  kind_q, kind_nxt;
	logic [7:0]  btc_q, btc_nxt;
	logic [15:0] mss_q, mss_nxt;
	logic [7:0]  wscale_q, wscale_nxt;
	logic        f_mss_q, f_mss_nxt;
	logic        f_win_q, f_win_nxt;
	logic        f_sack_q, f_sack_nxt;
	logic        f_ts_q, f_ts_nxt;
	logic [31:0] tsval_q, tsval_nxt;
	logic [31:0] tstime_q, tstime_nxt;

	// parse temporaries
	logic [5:0]  area;
	logic [7:0]  b;
	logic [8:0]  span;
	logic [7:0]  btc_dec;
	logic [7:0]  skip_len;
	logic        in_option;
	logic [15:0] mss_sat;

	// output register
	logic                summary_valid_q;
	tcpop_pkg::summary_t summary_q, summary_nxt;
	logic                emit;

	assign advance         = valid_s1 && (!req_s1.last_byte || !summary_valid_q || summary.ready);
	assign opt_bytes.ready = !valid_s1 || advance;
	assign accept          = opt_bytes.valid && opt_bytes.ready;
	assign emit            = advance && req_s1.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.option_byte  <= opt_bytes.option_byte;
			req_s1.area_length  <= opt_bytes.area_length;
			req_s1.last_byte    <= opt_bytes.last_byte;
			req_s1.current_time <= opt_bytes.current_time;
		end
	end

	always_comb begin
		area      = (req_s1.area_length > MAX_AREA) ? MAX_AREA : req_s1.area_length;
		b         = req_s1.option_byte;
		span      = {3'd0, pos_q} + {1'b0, b};
		btc_dec   = btc_q - 8'd1;
		skip_len  = b - tcpop_pkg::MIN_OPT_LEN;

		phase_nxt  = phase_q;
		pos_nxt    = (pos_q < tcpop_pkg::POS_MAX) ? pos_q + 6'd1 : pos_q;
		kind_nxt   = kind_q;
		btc_nxt    = btc_q;
		mss_nxt    = mss_q;
		wscale_nxt = wscale_q;
		f_mss_nxt  = f_mss_q;
		f_win_nxt  = f_win_q;
		f_sack_nxt = f_sack_q;
		f_ts_nxt   = f_ts_q;
		tsval_nxt  = tsval_q;
		tstime_nxt = tstime_q;

		in_option = (phase_q == tcpop_pkg::PH_LENGTH) || (phase_q == tcpop_pkg::PH_DATA)
		         || (phase_q == tcpop_pkg::PH_SKIP);

		if (pos_q >= area) begin
			if (phase_q == tcpop_pkg::PH_KIND) begin
				phase_nxt = tcpop_pkg::PH_STOPPED;
			end else if (in_option) begin
				phase_nxt = tcpop_pkg::PH_MALFORMED;
			end
		end else begin
			unique case (phase_q)
				tcpop_pkg::PH_KIND: begin
					if (b == tcpop_pkg::KIND_EOL) begin
						phase_nxt = tcpop_pkg::PH_STOPPED;
					end else if (b != tcpop_pkg::KIND_NOP) begin
						kind_nxt  = b;
						phase_nxt = tcpop_pkg::PH_LENGTH;
					end
				end
				tcpop_pkg::PH_LENGTH: begin
					// option must fit: pos + len - 1 <= area
					if (b < tcpop_pkg::MIN_OPT_LEN || span > ({3'd0, area} + 9'd1)) begin
						phase_nxt = tcpop_pkg::PH_MALFORMED;
					end else begin
						case (kind_q)
							tcpop_pkg::KIND_MSS: begin
								f_mss_nxt = 1'b1;
								mss_nxt   = '0;
								btc_nxt   = tcpop_pkg::MSS_BODY_BYTES;
								phase_nxt = tcpop_pkg::PH_DATA;
							end
							tcpop_pkg::KIND_WSCALE: begin
								f_win_nxt = 1'b1;
								btc_nxt   = tcpop_pkg::WSCALE_BODY_BYTES;
								phase_nxt = tcpop_pkg::PH_DATA;
							end
							tcpop_pkg::KIND_SACK_PERM: begin
								f_sack_nxt = 1'b1;
								phase_nxt  = tcpop_pkg::PH_KIND;
							end
							tcpop_pkg::KIND_TIMESTAMP: begin
								f_ts_nxt   = 1'b1;
								tsval_nxt  = '0;
								tstime_nxt = req_s1.current_time;
								btc_nxt    = tcpop_pkg::TS_BODY_BYTES;
								phase_nxt  = tcpop_pkg::PH_DATA;
							end
							default: begin
								btc_nxt   = skip_len;
								phase_nxt = (skip_len != 8'd0) ? tcpop_pkg::PH_SKIP
								                               : tcpop_pkg::PH_KIND;
							end
						endcase
					end
				end
				tcpop_pkg::PH_DATA: begin
					if (kind_q == tcpop_pkg::KIND_MSS) begin
						mss_nxt = {mss_q[7:0], b};
					end else if (kind_q == tcpop_pkg::KIND_WSCALE) begin
						wscale_nxt = b;
					end else if (btc_q > tcpop_pkg::TS_TSVAL_END) begin
						tsval_nxt = {tsval_q[23:0], b};
					end
					btc_nxt = btc_dec;
					if (btc_dec == 8'd0) begin
						phase_nxt = tcpop_pkg::PH_KIND;
					end
				end
				tcpop_pkg::PH_SKIP: begin
					btc_nxt = btc_dec;
					if (btc_dec == 8'd0) begin
						phase_nxt = tcpop_pkg::PH_KIND;
					end
				end
				default: ;
			endcase
		end

		// area ended inside an option
		if (req_s1.last_byte && ((phase_nxt == tcpop_pkg::PH_LENGTH)
		    || (phase_nxt == tcpop_pkg::PH_DATA) || (phase_nxt == tcpop_pkg::PH_SKIP))) begin
			phase_nxt = tcpop_pkg::PH_MALFORMED;
		end

		summary_nxt.mss_seen  = f_mss_nxt;
		summary_nxt.mss_value = f_mss_nxt ? mss_nxt : cfg.default_mss;
		mss_sat = (summary_nxt.mss_value > tcpop_pkg::TS_MSS_REDUCTION)
		        ? summary_nxt.mss_value - tcpop_pkg::TS_MSS_REDUCTION : 16'd0;
		if (!f_mss_nxt) begin
			summary_nxt.effective_mss = '0;
		end else if (cfg.timestamps_enabled) begin
			summary_nxt.effective_mss = mss_sat;
		end else begin
			summary_nxt.effective_mss = summary_nxt.mss_value;
		end
		summary_nxt.window_scale          = f_win_nxt ? wscale_nxt : {4'd0, cfg.default_wscale};
		summary_nxt.sack_permitted        = f_sack_nxt;
		summary_nxt.timestamp_seen        = f_ts_nxt;
		summary_nxt.recent_timestamp      = f_ts_nxt ? tsval_nxt : 32'd0;
		summary_nxt.timestamp_update_time = f_ts_nxt ? tstime_nxt : 32'd0;
		summary_nxt.malformed             = (phase_nxt == tcpop_pkg::PH_MALFORMED);
	end

	// window scale starts each area at the default, since a window option
	// cut short before its data byte still reports it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tcpop_pkg::PH_KIND;
			pos_q    <= '0;
			kind_q   <= '0;
			btc_q    <= '0;
			wscale_q <= {4'd0, tcpop_pkg::RST_DEFAULT_WSCALE};
			f_mss_q  <= 1'b0;
			f_win_q  <= 1'b0;
			f_sack_q <= 1'b0;
			f_ts_q   <= 1'b0;
		end else if (advance) begin
			if (req_s1.last_byte) begin
				phase_q  <= tcpop_pkg::PH_KIND;
				pos_q    <= '0;
				kind_q   <= '0;
				btc_q    <= '0;
				wscale_q <= {4'd0, cfg.default_wscale};
				f_mss_q  <= 1'b0;
				f_win_q  <= 1'b0;
				f_sack_q <= 1'b0;
				f_ts_q   <= 1'b0;
			end else begin
				phase_q  <= phase_nxt;
				pos_q    <= pos_nxt;
				kind_q   <= kind_nxt;
				btc_q    <= btc_nxt;
				wscale_q <= wscale_nxt;
				f_mss_q  <= f_mss_nxt;
				f_win_q  <= f_win_nxt;
				f_sack_q <= f_sack_nxt;
				f_ts_q   <= f_ts_nxt;
			end
		end
	end

	// captured values are only read under their flags
	always_ff @(posedge clk) begin
		if (advance) begin
			mss_q    <= mss_nxt;
			tsval_q  <= tsval_nxt;
			tstime_q <= tstime_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_valid_q <= 1'b0;
		end else if (emit) begin
			summary_valid_q <= 1'b1;
		end else if (summary.ready) begin
			summary_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			summary_q <= summary_nxt;
		end
	end

	assign summary.valid                 = summary_valid_q;
	assign summary.mss_value             = summary_q.mss_value;
	assign summary.effective_mss         = summary_q.effective_mss;
	assign summary.mss_seen              = summary_q.mss_seen;
	assign summary.window_scale          = summary_q.window_scale;
	assign summary.sack_permitted        = summary_q.sack_permitted;
	assign summary.timestamp_seen        = summary_q.timestamp_seen;
	assign summary.recent_timestamp      = summary_q.recent_timestamp;
	assign summary.timestamp_update_time = summary_q.timestamp_update_time;
	assign summary.malformed             = summary_q.malformed;

endmodule

[hw/rtl/tcp_option_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_option_parser
// Byte-serial TCP option area parser with APB-programmable defaults.
// ----------------------------------------------------------------------------
// Takes one option byte per cycle and emits one summary on the byte flagged
// last_byte. Each byte is registered on entry, parsed combinationally against
// the running option state and, if last, lands in the summary register. The
// sustained rate is one byte per cycle, set by the single parse-state update
// per byte; input stalls only while a finished summary is still waiting to be
// taken and the next last byte is ready to be parsed.
module tcp_option_parser #(
	parameter int MAX_OPTION_BYTES = tcpop_pkg::DEF_MAX_OPTION_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	tcpop_byte_if.sink                          opt_bytes,
	tcpop_summary_if.source                     summary,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tcpop_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [tcpop_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [tcpop_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready
);

	tcpop_pkg::cfg_t cfg;

	tcpop_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcpop_core #(
		.MAX_OPTION_BYTES (MAX_OPTION_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.opt_bytes (opt_bytes),
		.summary   (summary)
	);

endmodule
